// ----- hdl/u8ag_pkg.sv -----
// Shared constants and types for the UTF-8 to ASCII glyph mapper.
package u8ag_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CodeW  = 21;
    localparam int unsigned GlyphW = 7;
    localparam int unsigned CntW   = 2;

    // Lead byte classification
    localparam logic [ByteW-1:0] AsciiLim  = 8'h80;
    localparam logic [ByteW-1:0] Lead4Min  = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Min  = 8'hE0;
    localparam logic [ByteW-1:0] LeadMask2 = 8'h1F;
    localparam logic [ByteW-1:0] LeadMask3 = 8'h0F;
    localparam logic [ByteW-1:0] LeadMask4 = 8'h07;

    // Box drawing corner range
    localparam logic [CodeW-1:0] BoxLo = 21'h0250C;
    localparam logic [CodeW-1:0] BoxHi = 21'h0256C;

    // ASCII glyphs produced
    localparam logic [GlyphW-1:0] ChDot    = 7'h2E;
    localparam logic [GlyphW-1:0] ChColon  = 7'h3A;
    localparam logic [GlyphW-1:0] ChHash   = 7'h23;
    localparam logic [GlyphW-1:0] ChSlash  = 7'h2F;
    localparam logic [GlyphW-1:0] ChBslash = 7'h5C;
    localparam logic [GlyphW-1:0] ChBar    = 7'h7C;
    localparam logic [GlyphW-1:0] ChDash   = 7'h2D;
    localparam logic [GlyphW-1:0] ChQuote  = 7'h27;
    localparam logic [GlyphW-1:0] ChDquote = 7'h22;
    localparam logic [GlyphW-1:0] ChPlus   = 7'h2B;
    localparam logic [GlyphW-1:0] ChSpace  = 7'h20;

    // Decoder result for one accepted beat
    typedef struct packed {
        logic              emit;     // a glyph leaves with this beat
        logic              passthru; // plain ASCII byte, no mapping
        logic [GlyphW-1:0] ascii;
        logic [CodeW-1:0]  code;
        logic              last;
    } t_dec_out;

endpackage

// ----- hdl/u8ag_decode.sv -----
// Sequence tracker: lead/continuation handling and code point assembly.
module u8ag_decode
    import u8ag_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [ByteW-1:0] i_byte,
    input  logic             i_last,
    output t_dec_out         o_dec
);

    logic [CntW-1:0]  r_pending, n_pending;
    logic [CodeW-1:0] r_accum, n_accum;
    logic [CodeW-1:0] w_code;
    logic             w_done;

    always_comb begin
        o_dec     = '0;
        w_code    = '0;
        w_done    = 1'b0;
        n_pending = r_pending;
        n_accum   = r_accum;
        o_dec.last  = i_last;
        o_dec.ascii = i_byte[GlyphW-1:0];
        if (r_pending == '0) begin
            if (i_byte < AsciiLim) begin
                o_dec.emit     = 1'b1;
                o_dec.passthru = 1'b1;
            end else if (i_byte >= Lead4Min) begin
                w_code    = CodeW'(i_byte & LeadMask4);
                n_pending = CntW'(3);
            end else if (i_byte >= Lead3Min) begin
                w_code    = CodeW'(i_byte & LeadMask3);
                n_pending = CntW'(2);
            end else begin
                w_code    = CodeW'(i_byte & LeadMask2);
                n_pending = CntW'(1);
            end
        end else begin
            w_code    = {r_accum[CodeW-7:0], i_byte[5:0]};
            n_pending = r_pending - CntW'(1);
            w_done    = (n_pending == '0);
        end
        o_dec.code = w_code;
        n_accum    = w_code;
        if (!o_dec.passthru && (w_done || i_last)) begin
            o_dec.emit = 1'b1;
        end
        if (o_dec.emit) begin
            n_pending = '0;
            n_accum   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_accum   <= '0;
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

endmodule

// ----- hdl/u8ag_glyph.sv -----
// Code point to single-cell ASCII glyph lookup.
module u8ag_glyph
    import u8ag_pkg::*;
(
    input  logic [CodeW-1:0]  i_code,
    output logic [GlyphW-1:0] o_glyph
);

    always_comb begin
        case (i_code)
            21'h02591:                               o_glyph = ChDot;
            21'h02592:                               o_glyph = ChColon;
            21'h02593, 21'h02588:                    o_glyph = ChHash;
            21'h02571:                               o_glyph = ChSlash;
            21'h02572:                               o_glyph = ChBslash;
            21'h02502, 21'h02503, 21'h02551:         o_glyph = ChBar;
            21'h02500, 21'h02501, 21'h02550,
            21'h02014, 21'h02013:                    o_glyph = ChDash;
            21'h000B7, 21'h02022, 21'h02027:         o_glyph = ChDot;
            21'h02018, 21'h02019:                    o_glyph = ChQuote;
            21'h0201C, 21'h0201D:                    o_glyph = ChDquote;
            default: begin
                if (i_code inside {[BoxLo:BoxHi]}) begin
                    o_glyph = ChPlus;
                end else begin
                    o_glyph = ChSpace;
                end
            end
        endcase
    end

endmodule

// ----- hdl/utf8_to_ascii_glyph_map.sv -----
// Top level: UTF-8 byte stream in, ASCII glyph stream out.
//
// Slave side takes one raw UTF-8 byte per beat in i_s_tdata, with i_s_tlast
// marking the final byte of a line. Master side gives one ASCII glyph per
// beat in o_m_tdata[6:0] (bit 7 is zero), with o_m_tlast ending the line.
// A byte below 0x80 outside a sequence passes straight through. A lead byte
// opens a 2, 3 or 4 byte sequence; continuation bytes are taken blindly,
// six bits each. When the sequence closes, or the line ends inside it, the
// code point is looked up and one glyph leaves. Beats inside an open
// sequence produce no output beat.
// Throughput: one input beat per cycle, unless a stalled glyph holds the
// output register. Decode and the glyph lookup are combinational and sit
// between the sequence state and the output register.
// Reset (i_rst_n low, synchronous) clears the open sequence and empties the
// output register. When the receiver stalls, the glyph waits in the output
// register and o_s_tready stays high only if that register is being taken
// in the same cycle; a stall never drops or repeats a glyph.
module utf8_to_ascii_glyph_map
    import u8ag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // line_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] glyph, [7] zero
    output logic       o_m_tlast    // glyph_last
);

    t_dec_out          w_dec;
    logic [GlyphW-1:0] w_mapped;
    logic              w_accept;

    logic              r_valid;
    logic [GlyphW-1:0] r_glyph;
    logic              r_last;

    // Output register frees up when empty or drained this cycle
    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    u8ag_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_dec    (w_dec)
    );

    u8ag_glyph u_glyph (
        .i_code  (w_dec.code),
        .o_glyph (w_mapped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= w_accept && w_dec.emit;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_glyph <= w_dec.passthru ? w_dec.ascii : w_mapped;
            r_last  <= w_dec.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_glyph};
    assign o_m_tlast  = r_last;

endmodule

// ----- hdl/u8ag_checker.sv -----
// Port-level checks for the glyph mapper, bound to the top level.
module u8ag_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // Held beat stays put while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output beat changed under stall");

    // Input is only blocked by a stalled output beat
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input blocked without output stall");

    // Every glyph is 7-bit ASCII
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[7])
        else $error("glyph outside ASCII");

    // A line-ending byte always yields a beat in the next cycle
    a_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> o_m_tvalid && o_m_tlast)
        else $error("line end produced no glyph");

    // Reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind utf8_to_ascii_glyph_map u8ag_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ----- sim/utf8_to_ascii_glyph_map_chk.sv -----
`timescale 1ns / 100ps
// Scoreboard for the glyph mapper: predicts glyph beats from byte beats and checks them.
module utf8_to_ascii_glyph_map_chk
    import u8ag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // line_end
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [6:0] glyph, [7] zero
    input  logic       i_m_tlast,   // glyph_last
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [GlyphW-1:0] glyph;
        logic              last;
    } t_glyph_beat;

    t_glyph_beat      glyph_queue[$];
    logic [CntW-1:0]  seq_left;
    logic [CodeW-1:0] seq_code;
    int               fails;

    function automatic logic [GlyphW-1:0] glyph_for_code(input logic [CodeW-1:0] cp);
        case (cp)
            21'h02591:                                    return ChDot;
            21'h02592:                                    return ChColon;
            21'h02593, 21'h02588:                         return ChHash;
            21'h02571:                                    return ChSlash;
            21'h02572:                                    return ChBslash;
            21'h02502, 21'h02503, 21'h02551:              return ChBar;
            21'h02500, 21'h02501, 21'h02550,
            21'h02014, 21'h02013:                         return ChDash;
            21'h000B7, 21'h02022, 21'h02027:              return ChDot;
            21'h02018, 21'h02019:                         return ChQuote;
            21'h0201C, 21'h0201D:                         return ChDquote;
            default: begin
                if (cp >= BoxLo && cp <= BoxHi)
                    return ChPlus;
                return ChSpace;
            end
        endcase
    endfunction

    // One accepted byte beat: advance the sequence and queue the glyph it yields, if any.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [2:0]  seq_len;
        logic        done;
        t_glyph_beat beat;
        done = 1'b0;
        if (seq_left == '0) begin
            if (b < AsciiLim) begin
                beat.glyph = b[6:0];
                beat.last  = last;
                glyph_queue = {glyph_queue, beat};
                seq_code = '0;
                return;
            end
            seq_len  = (b >= Lead4Min) ? 3'd4 : (b >= Lead3Min) ? 3'd3 : 3'd2;
            seq_code = {13'b0, b & (8'h7F >> seq_len)};
            seq_left = CntW'(seq_len - 3'd1);
        end else begin
            seq_code = {seq_code[CodeW-7:0], b[5:0]};
            seq_left = seq_left - 1'b1;
            done     = (seq_left == '0);
        end
        if (done || last) begin
            beat.glyph = glyph_for_code(seq_code);
            beat.last  = last;
            glyph_queue = {glyph_queue, beat};
            seq_left = '0;
            seq_code = '0;
        end
    endtask

    task automatic report(input string what, input logic [7:0] expv, input logic [7:0] actv);
        fails++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, expv, actv);
    endtask

    always @(posedge i_clk) begin
        t_glyph_beat exp_beat;
        if (!i_rst_n) begin
            glyph_queue.delete();
            seq_left = '0;
            seq_code = '0;
            fails    = 0;
        end else begin
            // Output first: a glyph can never come from a byte taken at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                if (glyph_queue.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected glyph beat: expected none, actual tdata %h tlast %b",
                             $time, i_m_tdata, i_m_tlast);
                end else begin
                    exp_beat = glyph_queue.pop_front();
                    if (i_m_tdata[6:0] !== exp_beat.glyph)
                        report("glyph", {1'b0, exp_beat.glyph}, {1'b0, i_m_tdata[6:0]});
                    if (i_m_tdata[7] !== 1'b0)
                        report("tdata[7]", 8'h00, {7'b0, i_m_tdata[7]});
                    if (i_m_tlast !== exp_beat.last)
                        report("glyph_last", {7'b0, exp_beat.last}, {7'b0, i_m_tlast});
                end
            end
            if (i_s_tvalid && i_s_tready)
                decode_byte(i_s_tdata, i_s_tlast);
        end
        o_fail_count <= fails;
        o_pending    <= glyph_queue.size();
    end

endmodule

// ----- sim/utf8_to_ascii_glyph_map_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the UTF-8 to ASCII glyph mapper: byte stimulus, sink stalls, verdict.
module utf8_to_ascii_glyph_map_tb;
    import u8ag_pkg::*;

    // Idle patterns; each side switches pattern every few dozen beats so that
    // long back-to-back stretches alternate with heavy gaps.
    typedef enum int {IdleNone, IdleFull, IdleLight} t_idle_mode;

    localparam int MaxWait   = 12;
    localparam int ByteBeats = 725;   // directed beats plus about 700 random ones

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;    // [7:0] data_byte
    logic       i_s_tlast;    // line_end
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;    // [6:0] glyph, [7] zero
    logic       o_m_tlast;    // glyph_last

    int         fail_count;
    int         pending_glyphs;
    int         bytes_sent;

    t_idle_mode src_mode;
    int         src_left;
    t_idle_mode sink_mode;
    int         sink_left;

    // Code points with a glyph of their own, both edges of the box-corner range
    // plus their outside neighbors, and the unmapped neighbors 0x2590 and 0x2589.
    logic [CodeW-1:0] mapped_codes [27] = '{
        21'h02591, 21'h02592, 21'h02593, 21'h02588, 21'h02571, 21'h02572,
        21'h02502, 21'h02503, 21'h02551, 21'h02500, 21'h02501, 21'h02550,
        21'h02014, 21'h02013, 21'h000B7, 21'h02022, 21'h02027, 21'h02018,
        21'h02019, 21'h0201C, 21'h0201D, 21'h0250C, 21'h0256C, 21'h0250B,
        21'h0256D, 21'h02590, 21'h02589
    };

    utf8_to_ascii_glyph_map uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    utf8_to_ascii_glyph_map_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_glyphs)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_wait(input t_idle_mode mode);
        case (mode)
            IdleNone: return 0;
            IdleFull: return $urandom_range(0, MaxWait);
            default:  return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxWait) : 0;
        endcase
    endfunction

    task automatic refresh_mode(inout t_idle_mode mode, inout int left);
        if (left == 0) begin
            mode = t_idle_mode'($urandom_range(0, 2));
            left = $urandom_range(20, 80);
        end
        left--;
    endtask

    // Offer one byte beat, after a random gap, and hold it until it is taken.
    // Valid is only dropped when a gap is drawn, so a back-to-back beat never
    // sees valid lowered and raised at the same edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        refresh_mode(src_mode, src_left);
        gap = draw_wait(src_mode);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    // Encode cp as a len-byte UTF-8 sequence (overlong forms allowed) and send
    // the first nsend bytes; tlast goes on the final byte sent if end_line.
    task automatic send_seq(input logic [CodeW-1:0] cp, input int len, input int nsend,
                            input logic end_line);
        logic [CodeW-1:0] part;
        logic [7:0]       b;
        for (int i = 0; i < nsend; i++) begin
            part = cp >> (6 * (len - 1 - i));
            if (i == 0) begin
                case (len)
                    2:       b = 8'hC0 | (part[7:0] & LeadMask2);
                    3:       b = 8'hE0 | (part[7:0] & LeadMask3);
                    default: b = 8'hF0 | (part[7:0] & LeadMask4);
                endcase
            end else begin
                b = 8'h80 | {2'b00, part[5:0]};
            end
            send_byte(b, end_line && (i == nsend - 1));
        end
    endtask

    // Sink: a random stall before each glyph beat, then ready until one is taken.
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        sink_left = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            refresh_mode(sink_mode, sink_left);
            stall = draw_wait(sink_mode);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Source: reset, directed corners, then random lines.
    initial begin
        logic [CodeW-1:0] cp;
        logic [31:0]      rnd;
        int               pick;
        int               len;
        int               min_len;
        logic             end_line;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        bytes_sent = 0;
        src_left   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ASCII extremes, second one ends a line
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // well-formed glyphs, two three-byte and one two-byte; the second closes exactly at line end
        send_seq(21'h02591, 3, 3, 1'b0);
        send_seq(21'h0256C, 3, 3, 1'b1);
        send_seq(21'h000B7, 2, 2, 1'b0);
        // lead byte 0xF8 and above opens a four-byte sequence
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // stray continuation byte in lead position
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        // ASCII and lead values in continuation position are consumed blindly
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC0, 1'b0);
        // line ends inside a sequence: partial code point is emitted
        send_byte(8'hE2, 1'b0);
        send_byte(8'h95, 1'b1);
        // widest four-byte sequence
        send_seq(21'h10FFFF, 4, 4, 1'b1);

        // Random part: mostly well-formed sequences, some noise and truncation.
        while (bytes_sent < ByteBeats) begin
            pick     = $urandom_range(0, 99);
            end_line = ($urandom_range(0, 7) == 0);
            rnd      = $urandom;
            if (pick < 40) begin
                // code from the table above, sometimes anywhere in the box-corner range
                if ($urandom_range(0, 3) == 0)
                    cp = BoxLo + CodeW'($urandom_range(0, BoxHi - BoxLo));
                else
                    cp = mapped_codes[$urandom_range(0, 26)];
                min_len = (cp < 21'h00800) ? 2 : 3;
                len     = ($urandom_range(0, 3) == 0) ? $urandom_range(min_len, 4) : min_len;
                send_seq(cp, len, len, end_line);
            end else if (pick < 60) begin
                send_byte({1'b0, rnd[6:0]}, end_line);
            end else if (pick < 75) begin
                len = $urandom_range(2, 4);
                send_seq(rnd[CodeW-1:0], len, len, end_line);
            end else if (pick < 90) begin
                // raw noise: any byte value, any position
                send_byte(rnd[7:0], end_line);
            end else begin
                // sequence cut short by the end of the line
                len = $urandom_range(2, 4);
                send_seq(rnd[CodeW-1:0], len, $urandom_range(1, len - 1), 1'b1);
            end
        end

        i_s_tvalid <= 1'b0;
        // the scoreboard count is registered; let it see the last byte beat
        repeat (2) @(posedge i_clk);
        while (pending_glyphs != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/u8ag_pkg.sv
hdl/u8ag_decode.sv
hdl/u8ag_glyph.sv
hdl/utf8_to_ascii_glyph_map.sv
hdl/u8ag_checker.sv
sim/utf8_to_ascii_glyph_map_chk.sv
sim/utf8_to_ascii_glyph_map_tb.sv
